[hdl/clse_pkg.sv]
// Shared types and constants for the circular list sequence engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package clse_pkg;

    // Fixed field widths
    localparam int MODE_W  = 3;
    localparam int POS_W   = 5;
    localparam int WORD_W  = 32;
    localparam int LEN_W   = 5;
    localparam int STAT_W  = 2;

    // Defaults
    localparam int DEFAULT_CAPACITY = 16;
    localparam int QUEUE_DEPTH      = 2;

    // Request mode codes on the input channel
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LIST      = 3'd5;

    // Status codes on the result channel
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // Classified request kind
    typedef enum logic [2:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_BACK  = 3'd1,
        KIND_INS_POS   = 3'd2,
        KIND_DEL_FRONT = 3'd3,
        KIND_DEL_BACK  = 3'd4,
        KIND_LIST      = 3'd5,
        KIND_NOP       = 3'd6
    } kind_t;

    // Command handed from the front end to the executor
    typedef struct packed {
        kind_t               kind;
        logic                at_back;   // positional insert with position 0 or 1
        logic [POS_W-1:0]    position;
        logic [WORD_W-1:0]   value;
    } cmd_t;

endpackage

`default_nettype wire

[hdl/clse_front.sv]
// Front end: takes input transfers, decodes the mode into a command kind
// and holds one command until the queue takes it. Depends on clse_pkg.
`default_nettype none

module clse_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [clse_pkg::MODE_W-1:0] mode,
    input  wire logic [clse_pkg::POS_W-1:0]  position,
    input  wire logic [clse_pkg::WORD_W-1:0] value,
    output logic                             cmd_valid,
    input  wire logic                        cmd_ready,
    output clse_pkg::cmd_t                   cmd
);
    import clse_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    cmd_t decoded;

    // Classify the request
    always_comb
    begin
        decoded          = '0;
        decoded.position = position;
        decoded.value    = value;
        decoded.at_back  = (position <= POS_W'(1));
        case (mode)
            MODE_INS_FRONT: decoded.kind = KIND_INS_FRONT;
            MODE_INS_BACK:  decoded.kind = KIND_INS_BACK;
            MODE_INS_POS:   decoded.kind = KIND_INS_POS;
            MODE_DEL_FRONT: decoded.kind = KIND_DEL_FRONT;
            MODE_DEL_BACK:  decoded.kind = KIND_DEL_BACK;
            MODE_LIST:      decoded.kind = KIND_LIST;
            default:        decoded.kind = KIND_NOP;
        endcase
    end

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // Holding register
    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            cmd_next   = decoded;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

[hdl/clse_queue.sv]
// Short command queue between the front end and the executor.
// Depends on clse_pkg for the command type and depth.
`default_nettype none

module clse_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire clse_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output clse_pkg::cmd_t pop_cmd
);
    import clse_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           slots [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] fill_reg, fill_next;
    logic           do_push, do_pop;

    assign push_ready = (fill_reg != QCW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[hdl/clse_back.sv]
// Executor: holds the ring store and element count, carries out commands
// and drives the result register. Depends on clse_pkg.
`default_nettype none

module clse_back #(
    parameter int CAPACITY = clse_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire clse_pkg::cmd_t                cmd,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic [clse_pkg::WORD_W-1:0]        res_element,
    output logic [clse_pkg::STAT_W-1:0]        res_status,
    output logic                               res_last,
    output logic [clse_pkg::LEN_W-1:0]         res_length
);
    import clse_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_PLACE = 5'b00100,
        S_FETCH = 5'b01000,
        S_LIST  = 5'b10000
    } state_t;

    // Logical index to physical ring address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(k);
        if (s >= (CW+1)'(CAPACITY))
        begin
            s = s - (CW+1)'(CAPACITY);
        end
        return AW'(s);
    endfunction

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     tgt_reg, tgt_next;
    logic [WORD_W-1:0] val_reg, val_next;

    logic [WORD_W-1:0] mem [CAPACITY];
    logic [WORD_W-1:0] rd_data_reg;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_elem_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_last_reg;
    logic [LEN_W-1:0]  out_len_reg;

    logic              out_free, cmd_pop;
    logic              emit, emit_last;
    logic [WORD_W-1:0] emit_elem;
    logic [STAT_W-1:0] emit_status;
    logic [CMPW-1:0]   count_ext, pos_ext, count_next_ext;
    logic              full, empty;
    logic [AW-1:0]     head_m1, head_p1;

    assign out_free  = !out_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign cmd_pop   = cmd_valid && cmd_ready;

    assign count_ext = CMPW'(count_reg);
    assign pos_ext   = CMPW'(cmd.position);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign head_m1   = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_p1   = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    // Command sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        k_next      = k_reg;
        tgt_next    = tgt_reg;
        val_next    = val_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = cmd.value;
        rd_en       = 1'b0;
        rd_addr     = '0;
        emit        = 1'b0;
        emit_elem   = '0;
        emit_status = ST_OK;
        emit_last   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    case (cmd.kind)
                        KIND_INS_FRONT:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                emit_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = head_m1;
                                head_next  = head_m1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_INS_BACK:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                emit_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = phys(head_reg, count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_INS_POS:
                        begin
                            if (empty || (pos_ext > count_ext))
                            begin
                                emit        = 1'b1;
                                emit_status = ST_NOPOS;
                            end
                            else if (full)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_FULL;
                            end
                            else if (cmd.at_back)
                            begin
                                emit       = 1'b1;
                                wr_en      = 1'b1;
                                wr_addr    = phys(head_reg, count_reg);
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                // move the tail back one slot, last element first
                                val_next   = cmd.value;
                                tgt_next   = CW'(pos_ext - 1'b1);
                                k_next     = count_reg - 1'b1;
                                rd_en      = 1'b1;
                                rd_addr    = phys(head_reg, count_reg - 1'b1);
                                state_next = S_SHIFT;
                            end
                        end
                        KIND_DEL_FRONT:
                        begin
                            if (empty)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                head_next  = head_p1;
                                count_next = count_reg - 1'b1;
                                state_next = S_FETCH;
                            end
                        end
                        KIND_DEL_BACK:
                        begin
                            if (empty)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = phys(head_reg, count_reg - 1'b1);
                                count_next = count_reg - 1'b1;
                                state_next = S_FETCH;
                            end
                        end
                        KIND_LIST:
                        begin
                            if (empty)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                k_next     = '0;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, k_reg + 1'b1);
                wr_data = rd_data_reg;
                if (k_reg == tgt_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    k_next  = k_reg - 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = phys(head_reg, k_reg - 1'b1);
                end
            end
            S_PLACE:
            begin
                if (out_free)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = phys(head_reg, tgt_reg);
                    wr_data    = val_reg;
                    count_next = count_reg + 1'b1;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_elem  = rd_data_reg;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_elem = rd_data_reg;
                    emit_last = (k_reg == count_reg - 1'b1);
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next  = k_reg + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = phys(head_reg, k_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_next_ext = CMPW'(count_next);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        tgt_reg <= tgt_next;
        val_reg <= val_next;
        if (emit)
        begin
            out_elem_reg   <= emit_elem;
            out_status_reg <= emit_status;
            out_last_reg   <= emit_last;
            out_len_reg    <= count_next_ext[LEN_W-1:0];
        end
    end

    // Element store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_element = out_elem_reg;
    assign res_status  = out_status_reg;
    assign res_last    = out_last_reg;
    assign res_length  = out_len_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (k_reg >= tgt_reg) && (k_reg < count_reg))
        else $error("shift index out of range");

    a_list_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (k_reg < count_reg))
        else $error("list index beyond count");

    a_count_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(cmd_pop || (state_reg == S_PLACE)))
        else $error("count changed outside a command");

endmodule

`default_nettype wire

[hdl/circular_list_sequence_engine.sv]
// Top level of the circular list sequence engine: front end, command queue
// and executor. Depends on clse_pkg, clse_front, clse_queue, clse_back.
//
//  channel  | direction | tdata (low bit up)              | tuser       | tlast
//  s_axis   | in        | position[4:0], value[36:5]      | mode[2:0]   | -
//  m_axis   | out       | element[31:0], length[36:32]    | status[1:0] | final_res
//
// In the executor, front/back inserts, errors, unknown modes and appends
// (positional insert at position 0 or 1) finish in S_IDLE; deletes read the
// store, then emit in S_FETCH; a positional insert at position 2 or more
// shifts the tail in S_SHIFT and writes in S_PLACE; a listing uses S_LIST.
// Front end and queue register each command and hide executor stalls.
// Reset empties the list at once; no clearing pass is needed.
// A stalled result holds in the output register while the queue keeps filling.
`default_nettype none

module circular_list_sequence_engine #(
    parameter int CAPACITY = clse_pkg::DEFAULT_CAPACITY
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // position[4:0], value[36:5], zero pad
    input  wire logic [2:0]  s_axis_tuser,   // mode[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // element[31:0], length[36:32], zero pad
    output logic [1:0]       m_axis_tuser,   // status[1:0]
    output logic             m_axis_tlast    // final_res
);
    import clse_pkg::*;

    logic              fq_valid, fq_ready;
    cmd_t              fq_cmd;
    logic              qb_valid, qb_ready;
    cmd_t              qb_cmd;
    logic [WORD_W-1:0] res_element;
    logic [LEN_W-1:0]  res_length;

    clse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .mode      (s_axis_tuser[MODE_W-1:0]),
        .position  (s_axis_tdata[POS_W-1:0]),
        .value     (s_axis_tdata[POS_W+WORD_W-1:POS_W]),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    clse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    clse_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (qb_valid),
        .cmd_ready   (qb_ready),
        .cmd         (qb_cmd),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_element (res_element),
        .res_status  (m_axis_tuser),
        .res_last    (m_axis_tlast),
        .res_length  (res_length)
    );

    assign m_axis_tdata = {3'b000, res_length, res_element};

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for circular_list_sequence_engine: directed and random list requests
// are checked against a queue-based prediction of the ring contents.
// Depends on clse_pkg and the RTL of the block; stands alone otherwise.
`timescale 1ns / 1ps

module tb;
    import clse_pkg::*;

    localparam int CAP = DEFAULT_CAPACITY;

    // Modes the block ignores
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 390;

    typedef struct {
        bit                drain;   // hold off until every result is back
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] value;
    } list_req_t;

    typedef struct {
        logic [WORD_W-1:0] element;
        logic [STAT_W-1:0] status;
        logic              fin;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // position[4:0], value[36:5], zero pad
    logic [2:0]  s_axis_tuser = '0;    // mode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // element[31:0], length[36:32], zero pad
    logic [1:0]  m_axis_tuser;         // status[1:0]
    logic        m_axis_tlast;         // final_res

    list_req_t         pending_reqs[$];
    list_result_t      awaited_results[$];
    logic [WORD_W-1:0] ring_words[$];  // predicted contents, front first
    list_req_t         cur_req;
    int                burst_left = 8;
    int                gap_left = 0;
    int                rdy_left = 0;
    int                rdy_style = 0;
    int                err_count = 0;

    circular_list_sequence_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Apply one accepted request to the predicted ring and queue its results
    task automatic predict_list_op(input list_req_t r);
        logic [WORD_W-1:0] word;
        logic [STAT_W-1:0] st;
        int                n;
        word = '0;
        st   = ST_OK;
        n    = ring_words.size();
        case (r.mode)
            MODE_INS_FRONT, MODE_INS_BACK:
            begin
                if (n >= CAP)
                    st = ST_FULL;
                else if (r.mode == MODE_INS_FRONT)
                    ring_words.push_front(r.value);
                else
                    ring_words.push_back(r.value);
            end
            MODE_INS_POS:
            begin
                if (n == 0 || int'(r.pos) > n)
                    st = ST_NOPOS;
                else if (n >= CAP)
                    st = ST_FULL;
                else if (r.pos <= 1)
                    ring_words.push_back(r.value);   // before the front = at the back
                else
                    ring_words.insert(int'(r.pos) - 1, r.value);
            end
            MODE_DEL_FRONT:
            begin
                if (n == 0)
                    st = ST_EMPTY;
                else
                    word = ring_words.pop_front();
            end
            MODE_DEL_BACK:
            begin
                if (n == 0)
                    st = ST_EMPTY;
                else
                    word = ring_words.pop_back();
            end
            MODE_LIST:
            begin
                if (n == 0)
                    st = ST_EMPTY;
                else
                begin
                    for (int i = 0; i < n; i++)
                        awaited_results.push_back('{ring_words[i], ST_OK,
                                                    (i == n - 1), LEN_W'(n)});
                    return;
                end
            end
            default: ;   // spare modes: one plain ok result
        endcase
        awaited_results.push_back('{word, st, 1'b1, LEN_W'(ring_words.size())});
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                           input logic [WORD_W-1:0] v);
        pending_reqs.push_back('{1'b0, m, p, v});
    endtask

    task automatic add_drain();
        pending_reqs.push_back('{1'b1, MODE_SPARE_6, '0, '0});
    endtask

    // Any of the three insert kinds, positional ones at position 0 to 3 (back or near the front)
    task automatic add_insert();
        case ($urandom_range(0, 2))
            0: add_req(MODE_INS_FRONT, POS_W'($urandom_range(0, 31)), pick_word());
            1: add_req(MODE_INS_BACK, POS_W'($urandom_range(0, 31)), pick_word());
            default: add_req(MODE_INS_POS, POS_W'($urandom_range(0, 3)), pick_word());
        endcase
    endtask

    // Sender: bursts of transfers with random gaps, pausing at drain marks
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_list_op(cur_req);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && pending_reqs[0].drain)
                begin
                    if (awaited_results.size() == 0)
                        void'(pending_reqs.pop_front());
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, cur_req.value, cur_req.pos};
                    s_axis_tuser  <= cur_req.mode;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    function automatic void report_field(input string what, input logic [WORD_W-1:0] want,
                                         input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            err_count++;
        end
    endfunction

    // Receiver: checks each result transfer, stalls in phases of varying style
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual element %0h status %0d",
                             $time, m_axis_tdata[31:0], m_axis_tuser);
                    err_count++;
                end
                else
                begin
                    list_result_t want;
                    want = awaited_results.pop_front();
                    report_field("element", want.element, m_axis_tdata[31:0]);
                    report_field("status", 32'(want.status), 32'(m_axis_tuser));
                    report_field("final_res", 32'(want.fin), 32'(m_axis_tlast));
                    report_field("length", 32'(want.length), 32'(m_axis_tdata[36:32]));
                end
            end
            if (rdy_left == 0)
            begin
                rdy_style = $urandom_range(0, 3);
                rdy_left  = $urandom_range(4, 40);
            end
            else
                rdy_left--;
            case (rdy_style)
                0, 1: m_axis_tready <= 1'b1;
                2: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Run limit, well above the slowest legal run
    initial
    begin
        #10_000_000;
        $display("tb: errors");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        int n_rand;
        int pick;

        // Empty list: listing, both deletes, positional insert, spare modes
        add_req(MODE_LIST, 0, 0);
        add_req(MODE_DEL_FRONT, 0, 0);
        add_req(MODE_DEL_BACK, 0, 0);
        add_req(MODE_INS_POS, 1, 32'h1234_5678);
        add_req(MODE_SPARE_6, 0, 0);
        add_req(MODE_SPARE_7, 5'h1F, 32'hFFFF_FFFF);
        // Extremes, positions 0 and 1 append, a mid insert, missing positions
        add_req(MODE_INS_FRONT, 0, 32'h8000_0000);
        add_req(MODE_INS_BACK, 5'h1F, 32'h7FFF_FFFF);
        add_req(MODE_INS_POS, 0, 32'h0000_0000);
        add_req(MODE_INS_POS, 1, 32'hFFFF_FFFF);
        add_req(MODE_INS_POS, 2, 32'h0000_0005);
        add_req(MODE_INS_POS, 6, 32'hAAAA_AAAA);
        add_req(MODE_INS_POS, 5'h1F, 32'h5555_5555);
        add_req(MODE_LIST, 0, 0);
        // Shrink down to one element, remove it, list the empty ring
        add_req(MODE_DEL_FRONT, 0, 0);
        add_req(MODE_DEL_BACK, 0, 0);
        add_req(MODE_DEL_BACK, 0, 0);
        add_req(MODE_DEL_FRONT, 0, 0);
        add_req(MODE_DEL_BACK, 0, 0);
        add_req(MODE_LIST, 0, 0);
        add_drain();

        n_rand = 0;
        while (n_rand < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                // Fill past capacity, probe the full ring, then empty it
                add_req(MODE_INS_BACK, 0, pick_word());
                repeat (19) add_insert();
                add_req(MODE_LIST, 0, 0);
                add_req(MODE_INS_POS, POS_W'($urandom_range(17, 31)), pick_word());
                add_req(MODE_INS_POS, POS_W'($urandom_range(0, 16)), pick_word());
                repeat (17) add_req(($urandom_range(0, 1) == 1) ? MODE_DEL_FRONT
                                                                  : MODE_DEL_BACK, 0, 0);
                add_req(MODE_LIST, 0, 0);
                n_rand += 41;
            end
            else
            begin
                // Random mix with random positions
                repeat (24)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 20)
                        add_req(MODE_INS_POS, POS_W'(($urandom_range(0, 3) == 0) ?
                                $urandom_range(0, 31) : $urandom_range(0, 17)), pick_word());
                    else if (pick < 50)
                        add_insert();
                    else if (pick < 65)
                        add_req(MODE_DEL_FRONT, POS_W'($urandom_range(0, 31)), pick_word());
                    else if (pick < 80)
                        add_req(MODE_DEL_BACK, POS_W'($urandom_range(0, 31)), pick_word());
                    else if (pick < 92)
                        add_req(MODE_LIST, POS_W'($urandom_range(0, 31)), pick_word());
                    else
                        add_req(($urandom_range(0, 1) == 1) ? MODE_SPARE_6 : MODE_SPARE_7,
                                POS_W'($urandom_range(0, 31)), pick_word());
                end
                n_rand += 24;
                if ($urandom_range(0, 3) == 0)
                    add_drain();
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
